/* hdl/ple_pkg.sv */
// Package for the positional list engine: sizes, action and status codes,
// word types and the memory request bundle. No dependencies.
package ple_pkg;

  localparam int unsigned CAPACITY = 128;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned LEN_W    = 8;

  localparam logic [1:0] ACT_READ   = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ERR_RD  = 2'd1;
  localparam logic [1:0] ST_ERR_INS = 2'd2;
  localparam logic [1:0] ST_ERR_DEL = 2'd3;

  typedef struct packed {
    logic        [1:0]        action;
    logic        [POS_W-1:0]  position;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic        [1:0]        status;
    logic signed [DATA_W-1:0] read_value;
    logic        [LEN_W-1:0]  length;
  } out_word_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

endpackage

/* hdl/positional_list_engine.sv */
// Positional list engine: read, insert and delete by 1-based position.
// Every word ends in S_FIN, from which its result is loaded into the output register;
// an insert or delete first moves the affected entries by one place through the RAM in
// S_SHIFT, and an insert then writes its value in S_PLACE. No new word is taken until
// the result is handed on; a held result stalls the sequencer at its end.
// Reset clears the sequencer, entry count and output valid; the list RAM is kept.
module positional_list_engine
  import ple_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  logic              idle;
  logic              res_valid;
  logic              res_ready;
  out_word_t         res_word;
  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;

  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q, out_word_d;

  // Take a new word whenever the sequencer is idle; a result still sitting
  // in the output register does not block the next word from starting.
  assign in_ready_o = idle;

  // The sequencer may hand over its result when the output slot is empty
  // or is being drained in this same cycle.
  assign res_ready = !out_valid_q || out_ready_i;

  ple_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .idle_o      (idle),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_word_o  (res_word),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // List storage: one write and one registered read per cycle.
  ple_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: load a finished result, drop the valid once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_word_d  = res_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

/* hdl/ple_mem.sv */
// Generic simple dual-port RAM: one write and one registered read per cycle.
// No dependencies.
module ple_mem #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* hdl/ple_ctrl.sv */
// Sequencer for the positional list engine: range checks, entry count and
// the one-entry-per-cycle shift through the list RAM. Depends on ple_pkg.
module ple_ctrl
  import ple_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  in_word_t          in_word_i,
  output logic              idle_o,
  input  logic              res_ready_i,
  output logic              res_valid_o,
  output out_word_t         res_word_o,
  output mem_req_t          mem_req_o,
  input  logic [DATA_W-1:0] mem_rdata_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_PLACE = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;

  logic [2:0]        state_q, state_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic              pend_q, pend_d;
  logic [ADDR_W-1:0] pend_addr_q, pend_addr_d;
  logic              is_ins_q, is_ins_d;
  logic              rd_flag_q, rd_flag_d;
  logic [1:0]        status_q, status_d;
  logic [ADDR_W-1:0] place_addr_q, place_addr_d;
  logic [DATA_W-1:0] val_q, val_d;

  logic [POS_W-1:0]  pos;
  logic              pos_zero;
  logic              pos_above;
  logic              pos_above_end;
  logic              full;

  assign pos           = in_word_i.position;
  assign pos_zero      = (pos == '0);
  assign pos_above     = ({1'b0, pos} > {1'b0, cnt_q});
  assign pos_above_end = ({1'b0, pos} > ({1'b0, cnt_q} + 9'd1));
  assign full          = ({1'b0, cnt_q} >= 9'(CAPACITY));

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    rem_d        = rem_q;
    ptr_d        = ptr_q;
    pend_d       = 1'b0;
    pend_addr_d  = pend_addr_q;
    is_ins_d     = is_ins_q;
    rd_flag_d    = rd_flag_q;
    status_d     = status_q;
    place_addr_d = place_addr_q;
    val_d        = val_q;
    mem_req_o    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          rd_flag_d    = 1'b0;
          status_d     = ST_OK;
          state_d      = S_FIN;
          place_addr_d = ADDR_W'(pos - POS_W'(1));
          val_d        = in_word_i.value;
          case (in_word_i.action)
            ACT_READ: begin
              if (pos_zero || pos_above) begin
                status_d = ST_ERR_RD;
              end else begin
                rd_flag_d       = 1'b1;
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = ADDR_W'(pos - POS_W'(1));
              end
            end
            ACT_INSERT: begin
              if (pos_zero || pos_above_end || full) begin
                status_d = ST_ERR_INS;
              end else begin
                // move entries pos-1 .. count-1 up by one, top first
                is_ins_d = 1'b1;
                rem_d    = cnt_q - (pos - POS_W'(1));
                ptr_d    = ADDR_W'(cnt_q - LEN_W'(1));
                state_d  = S_SHIFT;
              end
            end
            ACT_DELETE: begin
              if (pos_zero || pos_above) begin
                status_d = ST_ERR_DEL;
              end else begin
                // move entries pos .. count-1 down by one, bottom first
                is_ins_d = 1'b0;
                rem_d    = cnt_q - pos;
                ptr_d    = ADDR_W'(pos);
                state_d  = S_SHIFT;
              end
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end
      end

      S_SHIFT: begin
        // write back the word fetched last cycle
        if (pend_q) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = pend_addr_q;
          mem_req_o.wdata = mem_rdata_i;
        end
        if (rem_q != '0) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = ptr_q;
          pend_d          = 1'b1;
          pend_addr_d     = is_ins_q ? (ptr_q + ADDR_W'(1)) : (ptr_q - ADDR_W'(1));
          ptr_d           = is_ins_q ? (ptr_q - ADDR_W'(1)) : (ptr_q + ADDR_W'(1));
          rem_d           = rem_q - LEN_W'(1);
        end else if (!pend_q) begin
          if (is_ins_q) begin
            state_d = S_PLACE;
          end else begin
            cnt_d   = cnt_q - LEN_W'(1);
            state_d = S_FIN;
          end
        end
      end

      S_PLACE: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = place_addr_q;
        mem_req_o.wdata = val_q;
        cnt_d           = cnt_q + LEN_W'(1);
        state_d         = S_FIN;
      end

      S_FIN: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign idle_o                = (state_q == S_IDLE);
  assign res_valid_o           = (state_q == S_FIN);
  assign res_word_o.status     = status_q;
  assign res_word_o.read_value = rd_flag_q ? mem_rdata_i : '0;
  assign res_word_o.length     = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q        <= rem_d;
    ptr_q        <= ptr_d;
    pend_addr_q  <= pend_addr_d;
    is_ins_q     <= is_ins_d;
    rd_flag_q    <= rd_flag_d;
    status_q     <= status_d;
    place_addr_q <= place_addr_d;
    val_q        <= val_d;
  end

endmodule

/* sim/ple_list_scoreboard_pkg.sv */
// List scoreboard for the positional list engine testbench: a queue-based model
// of the list that predicts each reply word and checks the replies in order.
// Depends on ple_pkg for widths, codes and word types.
package ple_list_scoreboard_pkg;
  import ple_pkg::*;

  class list_scoreboard;
    logic signed [DATA_W-1:0] entries_q[$];
    out_word_t                replies_due[$];
    int unsigned              failures;

    function new();
      failures = 0;
    endfunction

    function int length();
      return entries_q.size();
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    // Apply one accepted request word to the list and queue the reply it causes.
    function void apply_word(in_word_t w);
      out_word_t   r;
      int unsigned p;
      r = '0;
      r.status = ST_OK;
      p = 32'(w.position);
      case (w.action)
        ACT_READ: begin
          if (p == 0 || p > entries_q.size()) r.status = ST_ERR_RD;
          else r.read_value = entries_q[p-1];
        end
        ACT_INSERT: begin
          if (p == 0 || p > entries_q.size() + 1 || entries_q.size() >= CAPACITY)
            r.status = ST_ERR_INS;
          else entries_q.insert(p - 1, w.value);
        end
        ACT_DELETE: begin
          if (p == 0 || p > entries_q.size()) r.status = ST_ERR_DEL;
          else entries_q.delete(p - 1);
        end
        default: ;
      endcase
      r.length = LEN_W'(entries_q.size());
      replies_due.push_back(r);
    endfunction

    function void compare_reply(out_word_t got);
      out_word_t want;
      if (replies_due.size() == 0) begin
        $error("reply word with nothing outstanding: %p", got);
        failures++;
        return;
      end
      want = replies_due.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        failures++;
      end
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
        failures++;
      end
      if (got.length !== want.length) begin
        $error("length: expected %0d, got %0d", want.length, got.length);
        failures++;
      end
    endfunction
  endclass

endpackage

/* sim/tb_positional_list_engine.sv */
// Top-level testbench for the positional list engine: directed and random list
// traffic with bursty requests and a stalling receiver, checked by list_scoreboard.
// Depends on ple_pkg and ple_list_scoreboard_pkg.
module tb_positional_list_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;
  import ple_list_scoreboard_pkg::*;

  localparam logic [1:0]  ACT_UNUSED  = 2'd3;   // no operation: list left alone
  localparam int          RAND_ITEMS  = 550;
  localparam int          HOLD_CYCLES = 400;    // long receiver hold-off
  localparam int          TAIL_CYCLES = 200;    // longest shift plus margin
  localparam int unsigned LIMIT       = 1_000_000;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  list_scoreboard sb;
  int          burst_left = 0;
  int          words_sent = 0;
  bit          hold_req   = 1'b0;
  int unsigned cycles     = 0;

  positional_list_engine uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cap the run; a hung handshake ends here.
  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic in_word_t mk_word(logic [1:0] act, logic [POS_W-1:0] pos,
                                       logic signed [DATA_W-1:0] val);
    in_word_t w;
    w.action   = act;
    w.position = pos;
    w.value    = val;
    return w;
  endfunction

  // Bias toward the extremes now and then so sign and all-ones patterns show up.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '1;
      3:       return '0;
      default: return $signed($urandom());
    endcase
  endfunction

  // Mostly well-formed requests at legal positions; the rest is noise with
  // edge and random positions and every action code, the unused one too.
  function automatic in_word_t random_word(int len);
    int unsigned r;
    logic [POS_W-1:0] pos;
    r = $urandom_range(0, 99);
    if (r < 40 && len < CAPACITY)
      return mk_word(ACT_INSERT, POS_W'($urandom_range(1, len + 1)), pick_value());
    if (r < 62 && len > 0)
      return mk_word(ACT_READ, POS_W'($urandom_range(1, len)), pick_value());
    if (r < 82 && len > 0)
      return mk_word(ACT_DELETE, POS_W'($urandom_range(1, len)), pick_value());
    case ($urandom_range(0, 3))
      0:       pos = '0;
      1:       pos = '1;
      2:       pos = POS_W'(len + 1);
      default: pos = POS_W'($urandom_range(0, 255));
    endcase
    return mk_word(2'($urandom_range(0, 3)), pos, pick_value());
  endfunction

  // Offer one word in bursts: at the start of a burst drop valid for a random
  // gap (sometimes none), then hold valid and payload until the handshake.
  task automatic offer_word(in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    // Note the word here, in the sending process, so the next pick sees it.
    sb.apply_word(w);
    words_sent++;
  endtask

  task automatic offer(logic [1:0] act, logic [POS_W-1:0] pos,
                       logic signed [DATA_W-1:0] val);
    offer_word(mk_word(act, pos, val));
  endtask

  // Pause the sender until every expected reply word has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Receiver: segments of always-ready, light stalls and heavy stalls, plus a
  // long hold-off on request so the engine backs up and stalls its input.
  initial begin
    int mode;
    int seg;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 2);
      seg  = $urandom_range(8, 60);
      repeat (seg) begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 2) != 0);
          default: out_ready <= ($urandom_range(0, 5) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Check every reply word accepted at this edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.compare_reply(out_word);
  end

  initial begin
    int len;
    int r;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: errors on an empty list, inserts at front, middle and end with
    // extreme values, reads across the list, out-of-range accesses, the unused
    // action code, then deletes from the middle and the end, reads and a bad insert.
    offer(ACT_READ,   8'd1,   32'sd5);
    offer(ACT_READ,   8'd0,   32'sd0);
    offer(ACT_DELETE, 8'd1,   32'sd0);
    offer(ACT_INSERT, 8'd0,   32'sd7);
    offer(ACT_INSERT, 8'd2,   32'sd7);
    offer(ACT_INSERT, 8'd1,   32'sh7fff_ffff);
    offer(ACT_INSERT, 8'd2,   32'sh8000_0000);
    offer(ACT_INSERT, 8'd1,   -32'sd1);
    offer(ACT_INSERT, 8'd2,   32'sd0);
    for (int p = 1; p <= 4; p++) offer(ACT_READ, POS_W'(p), 32'sd0);
    offer(ACT_READ,   8'd5,   32'sd0);
    offer(ACT_READ,   8'd255, 32'sd0);
    offer(ACT_DELETE, 8'd5,   32'sd0);
    offer(ACT_DELETE, 8'd0,   32'sd0);
    offer(ACT_UNUSED, 8'd255, -32'sd1);
    offer(ACT_UNUSED, 8'd0,   32'sd0);
    offer(ACT_DELETE, 8'd2,   32'sd0);
    offer(ACT_DELETE, 8'd3,   32'sd0);
    offer(ACT_READ,   8'd1,   32'sd0);
    offer(ACT_READ,   8'd2,   32'sd0);
    offer(ACT_INSERT, 8'd255, 32'sd1);
    wait_drained();

    // Random mix; the list drifts upward since inserts dominate.
    repeat (180) begin
      if (words_sent == 60) hold_req = 1'b1;
      offer_word(random_word(sb.length()));
    end

    // Fill to capacity with inserts at random legal spots and a few reads.
    while (sb.length() < CAPACITY) begin
      len = sb.length();
      if (len == 100) hold_req = 1'b1;
      if (len > 0 && $urandom_range(0, 7) == 0)
        offer(ACT_READ, POS_W'($urandom_range(1, len)), pick_value());
      else
        offer(ACT_INSERT, POS_W'($urandom_range(1, len + 1)), pick_value());
    end

    // Full list: every insert is refused; the last slot still reads back, and reads and deletes past it are refused.
    offer(ACT_INSERT, 8'd1, pick_value());
    offer(ACT_INSERT, POS_W'(CAPACITY + 1), pick_value());
    offer(ACT_INSERT, POS_W'($urandom_range(2, CAPACITY)), pick_value());
    offer(ACT_READ,   POS_W'(CAPACITY), 32'sd0);
    offer(ACT_READ,   POS_W'(CAPACITY + 1), 32'sd0);
    offer(ACT_DELETE, POS_W'(CAPACITY + 1), 32'sd0);
    wait_drained();

    // Drain to empty: mostly deletes, some reads, a little noise.
    while (sb.length() > 0) begin
      len = sb.length();
      r = $urandom_range(0, 9);
      if (r < 6)      offer(ACT_DELETE, POS_W'($urandom_range(1, len)), pick_value());
      else if (r < 9) offer(ACT_READ, POS_W'($urandom_range(1, len)), pick_value());
      else            offer_word(random_word(len));
    end

    // Top up with random traffic.
    while (words_sent < RAND_ITEMS) offer_word(random_word(sb.length()));

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
